// File: rtl/core/silvt_pkg.sv
// Shared constants and codes for the silhouette vertex test unit.
// No dependencies; imported by the core and by its port checker.
package silvt_pkg;

  // Port widths fixed by the item and register formats.
  localparam int FIELD_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;
  localparam int CAM_W     = 48;

  // Saturation width of transformed and view coordinates.
  localparam int COORD_W = 16;

  // Derived datapath widths.
  localparam int WIDE_W = 40;                  // exact sums before saturation
  localparam int MAG_W  = COORD_W;             // magnitude of a saturated coordinate
  localparam int SQR_W  = 2 * COORD_W - 1;     // one squared magnitude
  localparam int SUM_W  = 2 * COORD_W + 1;     // sum of three squares
  localparam int LEN_W  = COORD_W;             // integer square root
  localparam int SQ_N   = LEN_W;               // one root bit per stage
  localparam int FRAC_W = 16;                  // numerator scale of the unit vector
  localparam int Q_W    = 16;                  // unit component magnitude, up to 2^15
  localparam int DIV_N  = Q_W;                 // one quotient bit per stage
  localparam int NUM_W  = MAG_W + FRAC_W + 1;
  localparam int DEN_W  = LEN_W + 1;
  localparam int PRD_W  = 2 * Q_W;
  localparam int DOT_W  = PRD_W + 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_X  = 3'd0,
    CFG_ROW_Y  = 3'd1,
    CFG_ROW_Z  = 3'd2,
    CFG_CAMERA = 3'd3,
    CFG_TOL    = 3'd4
  } cfg_idx_t;

endpackage

// File: rtl/core/silhouette_vertex_test_unit.sv
// Silhouette vertex test: transform, normalize, dot product and band test.
// Depends on silvt_pkg.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+----------------------------------------------
//  input    | in_valid / in_ready      | vertex_id, pos_x/y/z, normal_x/y/z
//  output   | out_valid / out_ready    | contour_id, contour_x/y/z
//  config   | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One vertex enters every cycle unless stalled; the pipeline has COORD_W + 23 register
// stages (39 at the default width): five front stages, the bit-per-stage square root
// (COORD_W stages), the bit-per-stage dividers (16 stages), the product stage and the
// output register. Vertices that fail the test leave the pipeline without a result.
// The whole pipeline advances together whenever the output register is empty or is
// being taken; a stall holds every stage, so nothing is lost or repeated.
// Reset clears the stage valid bits and loads the identity matrix, a zero camera and
// a tolerance of about 0.1. Configuration writes are taken in any cycle.
module silhouette_vertex_test_unit
  import silvt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FIELD_W-1:0]   vertex_id,
  input  logic signed [FIELD_W-1:0] pos_x,
  input  logic signed [FIELD_W-1:0] pos_y,
  input  logic signed [FIELD_W-1:0] pos_z,
  input  logic signed [FIELD_W-1:0] normal_x,
  input  logic signed [FIELD_W-1:0] normal_y,
  input  logic signed [FIELD_W-1:0] normal_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FIELD_W-1:0]   contour_id,
  output logic signed [FIELD_W-1:0] contour_x,
  output logic signed [FIELD_W-1:0] contour_y,
  output logic signed [FIELD_W-1:0] contour_z,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam longint CMAX = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;

  // Vertex identity carried alongside the math.
  typedef struct packed {
    logic [FIELD_W-1:0] id;
    logic [FIELD_W-1:0] px;
    logic [FIELD_W-1:0] py;
    logic [FIELD_W-1:0] pz;
  } tag_t;

  typedef struct packed {
    logic [2:0]            sgn;
    logic [2:0][MAG_W-1:0] mag;
  } vec_t;

  typedef struct packed {
    logic [SUM_W-1:0] rem;
    logic [LEN_W-1:0] root;
  } sq_t;

  typedef struct packed {
    tag_t tag;
    vec_t v;
    vec_t m;
    sq_t  sv;
    sq_t  sm;
  } sq_stage_t;

  typedef struct packed {
    logic [2:0][NUM_W-1:0] rem;
    logic [2:0][Q_W-1:0]   q;
    logic [DEN_W-1:0]      den;
    logic [2:0]            sgn;
    logic                  zero;
  } div_t;

  typedef struct packed {
    tag_t tag;
    div_t v;
    div_t m;
  } dv_stage_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [WIDE_W-1:0] x);
    logic signed [COORD_W-1:0] r;
    if (x > WIDE_W'(CMAX)) begin
      r = COORD_W'(CMAX);
    end else if (x < WIDE_W'(CMIN)) begin
      r = COORD_W'(CMIN);
    end else begin
      r = x[COORD_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [FIELD_W-1:0] coef(input logic [CFG_W-1:0] row, input int k);
    return row[FIELD_W*k +: FIELD_W];
  endfunction

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [COORD_W-1:0] x);
    logic signed [WIDE_W-1:0] w;
    w = WIDE_W'(x);
    return x[COORD_W-1] ? MAG_W'(-w) : MAG_W'(w);
  endfunction

  // One root bit: try (root + 2^b)^2 against the remaining radicand.
  function automatic sq_t sqrt_step(input sq_t s, input int b);
    sq_t r;
    logic [SUM_W:0] trial;
    r = s;
    trial = ((SUM_W+1)'(s.root) << (b + 1)) + ((SUM_W+1)'(1) << (2 * b));
    if ({1'b0, s.rem} >= trial) begin
      r.rem  = s.rem - trial[SUM_W-1:0];
      r.root = s.root | (LEN_W'(1) << b);
    end
    return r;
  endfunction

  function automatic div_t div_init(input vec_t v, input logic [LEN_W-1:0] len);
    div_t d;
    for (int i = 0; i < 3; i++) begin
      d.rem[i] = NUM_W'({v.mag[i], FRAC_W'(0)}) + NUM_W'(len);
      d.q[i]   = '0;
    end
    d.den  = {len, 1'b0};
    d.sgn  = v.sgn;
    d.zero = (len == '0);
    return d;
  endfunction

  // One quotient bit for all three components against the shared divisor.
  function automatic div_t div_step(input div_t d, input int b);
    div_t r;
    logic [NUM_W-1:0] sub;
    r = d;
    sub = NUM_W'(d.den) << b;
    for (int i = 0; i < 3; i++) begin
      if (d.rem[i] >= sub) begin
        r.rem[i] = d.rem[i] - sub;
        r.q[i]   = d.q[i] | (Q_W'(1) << b);
      end
    end
    return r;
  endfunction

  // Configuration registers.
  logic [CFG_W-1:0]   row_x, row_y, row_z;
  logic [CAM_W-1:0]   camera;
  logic [FIELD_W-1:0] tol;

  // Pipeline registers.
  logic en;
  logic a_vld, b_vld, c_vld, d_vld, e_vld, f_vld;
  tag_t a_tag, b_tag, c_tag, d_tag, e_tag, f_tag;
  logic signed [2:0][2:0][2*FIELD_W-1:0] a_pp, a_np;   // [row][column]
  logic signed [2:0][FIELD_W-1:0]        a_tr;
  logic signed [2:0][COORD_W-1:0]        b_t, b_m, c_v, c_m;
  vec_t d_v, d_m, e_v, e_m;
  logic [2:0][SQR_W-1:0] d_vsq, d_msq;
  logic [SUM_W-1:0] e_vs, e_ms;
  logic      sq_vld [SQ_N];
  sq_stage_t sq_st  [SQ_N];
  sq_stage_t sq_nx  [SQ_N];
  logic      dv_vld [DIV_N];
  dv_stage_t dv_st  [DIV_N];
  dv_stage_t dv_nx  [DIV_N];
  logic [2:0][PRD_W-1:0] f_prd;
  logic [2:0]            f_neg;

  logic signed [2:0][FIELD_W-1:0] pos_in, nrm_in;
  logic signed [2:0][COORD_W-1:0] t_next, m_next, v_next;
  logic signed [DOT_W-1:0] dot;
  logic [DOT_W-1:0]        adot;
  logic                    hit;

  assign cfg_ready = 1'b1;
  // Advance everything when the output slot is free or being emptied.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign pos_in = {pos_z, pos_y, pos_x};
  assign nrm_in = {normal_z, normal_y, normal_x};

  // Row sums, round to Q8.8, saturate; then the view vector.
  always_comb begin
    logic [CFG_W-1:0] rows [3];
    logic signed [WIDE_W-1:0] sp, sn;
    rows[0] = row_x;
    rows[1] = row_y;
    rows[2] = row_z;
    for (int r = 0; r < 3; r++) begin
      sp = WIDE_W'($signed(a_pp[r][0])) + WIDE_W'($signed(a_pp[r][1]))
         + WIDE_W'($signed(a_pp[r][2])) + (WIDE_W'($signed(a_tr[r])) <<< 8)
         + WIDE_W'(2048);
      sn = WIDE_W'($signed(a_np[r][0])) + WIDE_W'($signed(a_np[r][1]))
         + WIDE_W'($signed(a_np[r][2])) + WIDE_W'(2048);
      t_next[r] = sat_coord(sp >>> 12);
      m_next[r] = sat_coord(sn >>> 12);
      v_next[r] = sat_coord(-WIDE_W'(signed'(camera[FIELD_W*r +: FIELD_W]))
                            - WIDE_W'($signed(b_t[r])));
    end
  end

  // Square-root and divider steps.
  always_comb begin
    sq_stage_t src;
    dv_stage_t dsrc;
    for (int k = 0; k < SQ_N; k++) begin
      if (k == 0) begin
        src.tag     = e_tag;
        src.v       = e_v;
        src.m       = e_m;
        src.sv.rem  = e_vs;
        src.sv.root = '0;
        src.sm.rem  = e_ms;
        src.sm.root = '0;
      end else begin
        src = sq_st[k-1];
      end
      sq_nx[k]    = src;
      sq_nx[k].sv = sqrt_step(src.sv, SQ_N - 1 - k);
      sq_nx[k].sm = sqrt_step(src.sm, SQ_N - 1 - k);
    end
    for (int k = 0; k < DIV_N; k++) begin
      if (k == 0) begin
        dsrc.tag = sq_st[SQ_N-1].tag;
        dsrc.v   = div_init(sq_st[SQ_N-1].v, sq_st[SQ_N-1].sv.root);
        dsrc.m   = div_init(sq_st[SQ_N-1].m, sq_st[SQ_N-1].sm.root);
      end else begin
        dsrc = dv_st[k-1];
      end
      dv_nx[k].tag = dsrc.tag;
      dv_nx[k].v   = div_step(dsrc.v, DIV_N - 1 - k);
      dv_nx[k].m   = div_step(dsrc.m, DIV_N - 1 - k);
    end
  end

  // Signed dot product and band test.
  always_comb begin
    dot = '0;
    for (int i = 0; i < 3; i++) begin
      dot = f_neg[i] ? dot - DOT_W'(f_prd[i]) : dot + DOT_W'(f_prd[i]);
    end
    adot = dot[DOT_W-1] ? DOT_W'(-dot) : DOT_W'(dot);
    hit  = adot < DOT_W'({tol, 15'b0});
  end

  // Configuration writes; unknown indexes drop.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_x  <= CFG_W'(64'd4096);
      row_y  <= CFG_W'(64'd4096) << 16;
      row_z  <= CFG_W'(64'd4096) << 32;
      camera <= '0;
      tol    <= FIELD_W'(3277);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ROW_X:  row_x  <= cfg_data;
        CFG_ROW_Y:  row_y  <= cfg_data;
        CFG_ROW_Z:  row_z  <= cfg_data;
        CFG_CAMERA: camera <= cfg_data[CAM_W-1:0];
        CFG_TOL:    tol    <= cfg_data[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
      e_vld <= 1'b0;
      f_vld <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k < SQ_N; k++) sq_vld[k] <= 1'b0;
      for (int k = 0; k < DIV_N; k++) dv_vld[k] <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
      b_vld <= a_vld;
      c_vld <= b_vld;
      d_vld <= c_vld;
      e_vld <= d_vld;
      sq_vld[0] <= e_vld;
      for (int k = 1; k < SQ_N; k++) sq_vld[k] <= sq_vld[k-1];
      dv_vld[0] <= sq_vld[SQ_N-1];
      for (int k = 1; k < DIV_N; k++) dv_vld[k] <= dv_vld[k-1];
      f_vld <= dv_vld[DIV_N-1];
      // Drop vertices outside the band.
      out_valid <= f_vld && hit;
    end
  end

  // Datapath; holds on stall.
  always_ff @(posedge clk) begin
    logic [CFG_W-1:0] rows [3];
    logic [Q_W-1:0] qv, qm;
    rows[0] = row_x;
    rows[1] = row_y;
    rows[2] = row_z;
    if (en) begin
      // Stage a: the eighteen coefficient products.
      a_tag <= '{id: vertex_id, px: pos_x, py: pos_y, pz: pos_z};
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          a_pp[r][c] <= coef(rows[r], c) * $signed(pos_in[c]);
          a_np[r][c] <= coef(rows[r], c) * $signed(nrm_in[c]);
        end
        a_tr[r] <= coef(rows[r], 3);
      end
      // Stage b: transformed position and normal.
      b_tag <= a_tag;
      b_t   <= t_next;
      b_m   <= m_next;
      // Stage c: view vector.
      c_tag <= b_tag;
      c_v   <= v_next;
      c_m   <= b_m;
      // Stage d: magnitudes and squares.
      d_tag <= c_tag;
      for (int i = 0; i < 3; i++) begin
        d_v.sgn[i] <= c_v[i][COORD_W-1];
        d_v.mag[i] <= mag_of(c_v[i]);
        d_m.sgn[i] <= c_m[i][COORD_W-1];
        d_m.mag[i] <= mag_of(c_m[i]);
        d_vsq[i]   <= SQR_W'(mag_of(c_v[i])) * SQR_W'(mag_of(c_v[i]));
        d_msq[i]   <= SQR_W'(mag_of(c_m[i])) * SQR_W'(mag_of(c_m[i]));
      end
      // Stage e: squared lengths.
      e_tag <= d_tag;
      e_v   <= d_v;
      e_m   <= d_m;
      e_vs  <= SUM_W'(d_vsq[0]) + SUM_W'(d_vsq[1]) + SUM_W'(d_vsq[2]);
      e_ms  <= SUM_W'(d_msq[0]) + SUM_W'(d_msq[1]) + SUM_W'(d_msq[2]);
      for (int k = 0; k < SQ_N; k++) sq_st[k] <= sq_nx[k];
      for (int k = 0; k < DIV_N; k++) dv_st[k] <= dv_nx[k];
      // Stage f: component products of the unit vectors; zero length gives zero.
      f_tag <= dv_st[DIV_N-1].tag;
      for (int i = 0; i < 3; i++) begin
        qv = dv_st[DIV_N-1].v.zero ? '0 : dv_st[DIV_N-1].v.q[i];
        qm = dv_st[DIV_N-1].m.zero ? '0 : dv_st[DIV_N-1].m.q[i];
        f_prd[i] <= PRD_W'(qv) * PRD_W'(qm);
        f_neg[i] <= dv_st[DIV_N-1].v.sgn[i] ^ dv_st[DIV_N-1].m.sgn[i];
      end
      // Output register.
      contour_id <= f_tag.id;
      contour_x  <= f_tag.px;
      contour_y  <= f_tag.py;
      contour_z  <= f_tag.pz;
    end
  end

endmodule

// File: rtl/core/silvt_port_checker.sv
// Port-level checks for the silhouette vertex test unit, bound to the top level.
// Depends on silvt_pkg and silhouette_vertex_test_unit.
module silvt_port_checker
  import silvt_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               cfg_ready,
  input logic [FIELD_W-1:0] contour_id,
  input logic [FIELD_W-1:0] contour_x
);

  // Hold a stalled result transaction unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(contour_id) && $stable(contour_x))
    else $error("result transaction changed while stalled");

  // Take input whenever the output slot is free.
  a_in_free: assert property (@(posedge clk) !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Take input in the same cycle a result leaves.
  a_in_drain: assert property (@(posedge clk) out_valid && out_ready |-> in_ready)
    else $error("input stalled while result drains");

  // Drop any result after reset.
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  a_cfg_open: assert property (@(posedge clk) cfg_ready)
    else $error("configuration port stalled");

endmodule

bind silhouette_vertex_test_unit silvt_port_checker u_port_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .cfg_ready  (cfg_ready),
  .contour_id (contour_id),
  .contour_x  (contour_x)
);
